### src/tcph_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcph_pkg: shared types and constants
// Phase codes, flags and the result record of the TPKT/COTP PDU header parser.
// ----------------------------------------------------------------------------
package tcph_pkg;

    typedef enum logic [3:0] {
        PH_TPKT      = 4'd0,
        PH_COTP_LEN  = 4'd1,
        PH_COTP_TYPE = 4'd2,
        PH_SKIP      = 4'd3,
        PH_PDU_ID    = 4'd4,
        PH_CLASSIC   = 4'd5,
        PH_PLUS_HDR  = 4'd6,
        PH_DIGEST    = 4'd7,
        PH_OPCODE    = 4'd8,
        PH_DRAIN     = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_CLASSIC  = 2'd1,
        KIND_PLUS     = 2'd2,
        KIND_REJECTED = 2'd3
    } t_kind;

    localparam logic [7:0] TPKT_VERSION = 8'h03;
    localparam logic [7:0] ID_CLASSIC   = 8'h32;
    localparam logic [7:0] ID_PLUS      = 8'h72;
    localparam logic [3:0] COTP_DT      = 4'hF;
    localparam logic [7:0] ROS_ACK      = 8'h02;
    localparam logic [7:0] ROS_ACK_DATA = 8'h03;
    localparam logic [15:0] MIN_LENGTH  = 16'd4;

    typedef struct packed {
        logic        dir;
        t_kind       kind;
        logic        hdr_valid;
        logic [7:0]  rosctr;
        logic [15:0] pdu_ref;
        logic [7:0]  err_class;
        logic [7:0]  err_code;
        logic        func_present;
        logic [7:0]  func_code;
        logic        op_present;
        logic [7:0]  opcode;
    } t_result;

endpackage
`default_nettype wire

### src/tpkt_cotp_pdu_header_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpkt_cotp_pdu_header_parser: ISO-on-TCP frame header parser
// Tracks TPKT/COTP framing per direction and reports PDU header fields.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle for either direction while the result queue
// has room; each byte updates that direction's frame state. A frame's result is
// registered into a four-entry result queue that feeds the output port;
// input stalls only while that queue is full. A bad version or short length
// gives one rejection result, after which all bytes are taken and dropped.
module tpkt_cotp_pdu_header_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_direction,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_chunk_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_result_direction,
    output logic [1:0]       o_frame_kind,
    output logic             o_header_valid,
    output logic [7:0]       o_rosctr,
    output logic [15:0]      o_pdu_ref,
    output logic [7:0]       o_error_class,
    output logic [7:0]       o_error_code,
    output logic             o_func_present,
    output logic [7:0]       o_func_code,
    output logic             o_opcode_present,
    output logic [7:0]       o_opcode
);
    import tcph_pkg::*;

    t_result res, q_out;
    logic    res_valid, q_full, unused_last;

    assign unused_last = i_chunk_last;

    tcph_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_dir(i_direction), .i_byte(i_payload_byte),
        .o_res_valid(res_valid), .o_res(res), .i_q_full(q_full)
    );

    tcph_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(res_valid), .i_data(res),
        .o_full(q_full), .o_valid(o_valid), .i_pop(i_ready), .o_data(q_out)
    );

    assign o_result_direction = q_out.dir;
    assign o_frame_kind       = q_out.kind;
    assign o_header_valid     = q_out.hdr_valid;
    assign o_rosctr           = q_out.rosctr;
    assign o_pdu_ref          = q_out.pdu_ref;
    assign o_error_class      = q_out.err_class;
    assign o_error_code       = q_out.err_code;
    assign o_func_present     = q_out.func_present;
    assign o_func_code        = q_out.func_code;
    assign o_opcode_present   = q_out.op_present;
    assign o_opcode           = q_out.opcode;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !o_ready) else $error("input taken with full queue");
    a_hdr_needs_classic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_header_valid) |-> (o_frame_kind == KIND_CLASSIC))
        else $error("header valid on non-classic result");
    a_codes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_func_present && o_opcode_present))
        else $error("function and opcode both present");
endmodule
`default_nettype wire

### src/tcph_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcph_parser: front end
// Accepts one byte per cycle while the queue has room, walks the per-direction
// frame state and emits a result record on frame completion or stream rejection.
// ----------------------------------------------------------------------------
module tcph_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_dir,
    input  wire logic [7:0]        i_byte,
    output logic                   o_res_valid,
    output tcph_pkg::t_result      o_res,
    input  wire logic              i_q_full
);
    import tcph_pkg::*;

    logic [15:0] r_pos   [2];
    logic [15:0] r_len   [2];
    logic [7:0]  r_cotp  [2];
    logic [7:0]  r_skip  [2];
    t_phase      r_ph    [2];
    logic [7:0]  r_ros   [2];
    logic [15:0] r_ref   [2];
    logic [15:0] r_plen  [2];
    logic [7:0]  r_ecl   [2];
    logic [7:0]  r_eco   [2];
    logic [7:0]  r_fc    [2];
    logic [7:0]  r_op    [2];
    logic        r_fcl   [2];
    logic        r_fpl   [2];
    logic        r_fhdr  [2];
    logic        r_fcode [2];
    logic        r_rej;

    logic [15:0] n_pos, n_len, n_ref, n_plen;
    logic [7:0]  n_cotp, n_skip, n_ros, n_ecl, n_eco, n_fc, n_op, k;
    t_phase      n_ph;
    logic        n_fcl, n_fpl, n_fhdr, n_fcode, rej_now, done, ack, fire, d;
    logic [15:0] len3;

    assign o_ready = !i_q_full;
    assign fire    = i_valid && o_ready && !r_rej;
    assign d       = i_dir;

    always_comb begin
        n_pos = r_pos[d]; n_len = r_len[d]; n_cotp = r_cotp[d]; n_skip = r_skip[d];
        n_ph = r_ph[d]; n_ros = r_ros[d]; n_ref = r_ref[d]; n_plen = r_plen[d];
        n_ecl = r_ecl[d]; n_eco = r_eco[d]; n_fc = r_fc[d]; n_op = r_op[d];
        n_fcl = r_fcl[d]; n_fpl = r_fpl[d]; n_fhdr = r_fhdr[d]; n_fcode = r_fcode[d];
        rej_now = 1'b0;
        k = r_skip[d] + 8'd1;
        ack = (r_ros[d] == ROS_ACK) || (r_ros[d] == ROS_ACK_DATA);
        len3 = {r_len[d][15:8], i_byte};
        case (r_ph[d])
            PH_TPKT: begin
                if (r_pos[d] == 16'd0) n_ros = i_byte;
                else if (r_pos[d] == 16'd2) n_len = {i_byte, 8'd0};
                else if (r_pos[d] == 16'd3) begin
                    n_len = len3;
                    n_ros = 8'd0;
                    if (r_ros[d] != TPKT_VERSION || len3 < MIN_LENGTH) rej_now = 1'b1;
                    else n_ph = PH_COTP_LEN;
                end
            end
            PH_COTP_LEN: begin
                n_cotp = i_byte;
                n_ph = PH_COTP_TYPE;
            end
            PH_COTP_TYPE: begin
                if (i_byte[7:4] != COTP_DT) n_ph = PH_DRAIN;
                else if (r_cotp[d] > 8'd1) begin
                    n_skip = r_cotp[d] - 8'd1;
                    n_ph = PH_SKIP;
                end else n_ph = PH_PDU_ID;
            end
            PH_SKIP: begin
                n_skip = r_skip[d] - 8'd1;
                if (n_skip == 8'd0) n_ph = PH_PDU_ID;
            end
            PH_PDU_ID: begin
                n_skip = 8'd0;
                if (i_byte == ID_CLASSIC) begin
                    n_fcl = 1'b1; n_ph = PH_CLASSIC;
                end else if (i_byte == ID_PLUS) begin
                    n_fpl = 1'b1; n_ph = PH_PLUS_HDR;
                end else n_ph = PH_DRAIN;
            end
            PH_CLASSIC: begin
                n_skip = k;
                // fields are plain loads into a capture that is cleared when each frame ends
                case (k)
                    8'd1:  n_ros = i_byte;
                    8'd4:  n_ref[15:8] = i_byte;
                    8'd5:  n_ref[7:0] = i_byte;
                    8'd6:  n_plen[15:8] = i_byte;
                    8'd7:  n_plen[7:0] = i_byte;
                    8'd9:  n_fhdr = 1'b1;
                    8'd10: if (ack) n_ecl = i_byte;
                    8'd11: if (ack) n_eco = i_byte;
                    default: ;
                endcase
                if (k == (ack ? 8'd12 : 8'd10)) begin
                    if (r_plen[d] != 16'd0) begin
                        n_fc = i_byte; n_fcode = 1'b1;
                    end
                    n_ph = PH_DRAIN;
                end
            end
            PH_PLUS_HDR: begin
                n_skip = k;
                if (k == 8'd4) begin
                    if (i_byte == 8'd0) n_ph = PH_OPCODE;
                    else begin
                        n_skip = i_byte; n_ph = PH_DIGEST;
                    end
                end
            end
            PH_DIGEST: begin
                n_skip = r_skip[d] - 8'd1;
                if (n_skip == 8'd0) n_ph = PH_OPCODE;
            end
            PH_OPCODE: begin
                n_op = i_byte; n_fcode = 1'b1; n_ph = PH_DRAIN;
            end
            default: ;
        endcase
        n_pos = r_pos[d] + 16'd1;
        done = !rej_now && (n_ph != PH_TPKT) && (n_pos == n_len);
    end

    always_comb begin
        o_res = '0;
        o_res.dir = d;
        if (rej_now) o_res.kind = KIND_REJECTED;
        else begin
            o_res.kind = n_fcl ? KIND_CLASSIC : (n_fpl ? KIND_PLUS : KIND_NONE);
            o_res.hdr_valid = n_fcl && n_fhdr;
            if (n_fcl && n_fhdr) begin
                o_res.rosctr = n_ros; o_res.pdu_ref = n_ref;
                o_res.err_class = n_ecl; o_res.err_code = n_eco;
            end
            o_res.func_present = n_fcl && n_fcode;
            o_res.func_code = (n_fcl && n_fcode) ? n_fc : 8'd0;
            o_res.op_present = n_fpl && n_fcode;
            o_res.opcode = (n_fpl && n_fcode) ? n_op : 8'd0;
        end
    end
    assign o_res_valid = fire && (rej_now || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rej <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_pos[i] <= '0; r_len[i] <= '0; r_cotp[i] <= '0; r_skip[i] <= '0;
                r_ph[i] <= PH_TPKT; r_ros[i] <= '0; r_ref[i] <= '0; r_plen[i] <= '0;
                r_ecl[i] <= '0; r_eco[i] <= '0; r_fc[i] <= '0; r_op[i] <= '0;
                r_fcl[i] <= 1'b0; r_fpl[i] <= 1'b0; r_fhdr[i] <= 1'b0;
                r_fcode[i] <= 1'b0;
            end
        end else if (fire) begin
            if (rej_now) r_rej <= 1'b1;
            if (done) begin
                r_pos[d] <= '0; r_len[d] <= '0; r_cotp[d] <= '0; r_skip[d] <= '0;
                r_ph[d] <= PH_TPKT; r_ros[d] <= '0; r_ref[d] <= '0; r_plen[d] <= '0;
                r_ecl[d] <= '0; r_eco[d] <= '0; r_fc[d] <= '0; r_op[d] <= '0;
                r_fcl[d] <= 1'b0; r_fpl[d] <= 1'b0; r_fhdr[d] <= 1'b0;
                r_fcode[d] <= 1'b0;
            end else begin
                r_pos[d] <= n_pos; r_len[d] <= n_len; r_cotp[d] <= n_cotp;
                r_skip[d] <= n_skip; r_ph[d] <= n_ph; r_ros[d] <= n_ros;
                r_ref[d] <= n_ref; r_plen[d] <= n_plen; r_ecl[d] <= n_ecl;
                r_eco[d] <= n_eco; r_fc[d] <= n_fc; r_op[d] <= n_op;
                r_fcl[d] <= n_fcl; r_fpl[d] <= n_fpl; r_fhdr[d] <= n_fhdr;
                r_fcode[d] <= n_fcode;
            end
        end
    end
endmodule
`default_nettype wire

### src/tcph_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcph_queue: result queue
// Four-entry FIFO of result records between the parser and the output port.
// ----------------------------------------------------------------------------
module tcph_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire tcph_pkg::t_result i_data,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output tcph_pkg::t_result      o_data
);
    import tcph_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, push} - {2'd0, pop};
        end
    end
endmodule
`default_nettype wire
